>>> rtl/epoch_to_calendar_date_time_core_defines.svh
// Assertion macros used by the checker file of the epoch converter
`ifndef EPOCH_TO_CALENDAR_DATE_TIME_CORE_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATE_TIME_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define ECTD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ECTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ectd_pkg.sv
// Shared types, constants and microcode table of the epoch converter
package ectd_pkg;

   // Calendar constants
   localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
   localparam logic [11:0] RTC_BASE_YEAR    = 12'd2000;
   localparam logic [6:0]  EPOCH_YEAR_MOD100 = 7'(1970 % 100);
   localparam logic [8:0]  EPOCH_YEAR_MOD400 = 9'(1970 % 400);
   localparam logic [6:0]  LAST_MOD100      = 7'd99;
   localparam logic [8:0]  LAST_MOD400      = 9'd399;
   localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
   localparam logic [8:0]  DAYS_LEAP_YEAR   = 9'd366;

   // Zero-based month indexes used by the month table
   localparam logic [3:0] MONTH_FEB = 4'd1;
   localparam logic [3:0] MONTH_APR = 4'd3;
   localparam logic [3:0] MONTH_JUN = 4'd5;
   localparam logic [3:0] MONTH_SEP = 4'd8;
   localparam logic [3:0] MONTH_NOV = 4'd10;
   localparam logic [3:0] MONTH_DEC = 4'd11;

   // Reciprocal constants: x / D == (x * RECIP) >> SHIFT for every 32-bit x
   localparam logic [31:0] DIV60_VALUE = 32'd60;
   localparam logic [31:0] DIV60_RECIP = 32'h8888_8889;
   localparam int          DIV60_SHIFT = 37;
   localparam logic [31:0] DIV24_VALUE = 32'd24;
   localparam logic [31:0] DIV24_RECIP = 32'hAAAA_AAAB;
   localparam int          DIV24_SHIFT = 36;

   typedef logic [3:0] step_type;

   // Microcode addresses
   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_MUL_SEC  = 4'd1;
   localparam step_type STEP_REM_SEC  = 4'd2;
   localparam step_type STEP_MUL_MIN  = 4'd3;
   localparam step_type STEP_REM_MIN  = 4'd4;
   localparam step_type STEP_MUL_HOUR = 4'd5;
   localparam step_type STEP_REM_HOUR = 4'd6;
   localparam step_type STEP_YEAR     = 4'd7;
   localparam step_type STEP_MONTH    = 4'd8;
   localparam step_type STEP_EMIT     = 4'd9;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_REM,
      OP_YEAR,
      OP_MONTH,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      SEQ_WAIT,
      SEQ_NEXT,
      SEQ_LOOP,
      SEQ_JUMP
   } seq_type;

   typedef enum logic {
      DIV_60,
      DIV_24
   } div_type;

   typedef enum logic [1:0] {
      FIELD_SEC,
      FIELD_MIN,
      FIELD_HOUR
   } field_type;

   typedef struct packed {
      op_type    op;
      div_type   div;
      field_type field;
      seq_type   seq;
      step_type  branch;
   } ctrl_word_type;

   typedef struct packed {
      logic loop_exit;
   } dp_status_type;

   // Read-only control store: one word per step
   function automatic ctrl_word_type microcode(input step_type addr);
      ctrl_word_type w;
      w = '{op: OP_NOP, div: DIV_60, field: FIELD_SEC, seq: SEQ_JUMP, branch: STEP_IDLE};
      unique case (addr)
         STEP_IDLE: begin
            w.op  = OP_LOAD;
            w.seq = SEQ_WAIT;
         end
         STEP_MUL_SEC: begin
            w.op  = OP_MUL;
            w.seq = SEQ_NEXT;
         end
         STEP_REM_SEC: begin
            w.op  = OP_REM;
            w.seq = SEQ_NEXT;
         end
         STEP_MUL_MIN: begin
            w.op  = OP_MUL;
            w.seq = SEQ_NEXT;
         end
         STEP_REM_MIN: begin
            w.op    = OP_REM;
            w.field = FIELD_MIN;
            w.seq   = SEQ_NEXT;
         end
         STEP_MUL_HOUR: begin
            w.op  = OP_MUL;
            w.div = DIV_24;
            w.seq = SEQ_NEXT;
         end
         STEP_REM_HOUR: begin
            w.op    = OP_REM;
            w.div   = DIV_24;
            w.field = FIELD_HOUR;
            w.seq   = SEQ_NEXT;
         end
         STEP_YEAR: begin
            w.op     = OP_YEAR;
            w.seq    = SEQ_LOOP;
            w.branch = STEP_MONTH;
         end
         STEP_MONTH: begin
            w.op     = OP_MONTH;
            w.seq    = SEQ_LOOP;
            w.branch = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.op     = OP_EMIT;
            w.seq    = SEQ_JUMP;
            w.branch = STEP_IDLE;
         end
         default: begin
            w.op     = OP_NOP;
            w.seq    = SEQ_JUMP;
            w.branch = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Days in a zero-based month, February follows the leap flag
   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      len = 5'd31;
      if (mon == MONTH_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (mon == MONTH_APR || mon == MONTH_JUN ||
                   mon == MONTH_SEP || mon == MONTH_NOV) begin
         len = 5'd30;
      end
      return len;
   endfunction

endpackage

>>> rtl/ectd_datapath.sv
// Datapath of the epoch converter: reciprocal divider, year and month walk
module ectd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ectd_pkg::ctrl_word_type ctrl,
   input  logic [31:0]           req_epoch_seconds,
   output ectd_pkg::dp_status_type status,
   output logic                  rsp_valid,
   output logic [5:0]            rsp_second_of_minute,
   output logic [5:0]            rsp_minute_of_hour,
   output logic [4:0]            rsp_hour_of_day,
   output logic [4:0]            rsp_day_of_month,
   output logic [3:0]            rsp_month_of_year,
   output logic [11:0]           rsp_full_year,
   output logic [7:0]            rsp_short_year
);
   import ectd_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [11:0] year_ff, year_in;
   logic [6:0]  y100_ff, y100_in;
   logic [8:0]  y400_ff, y400_in;
   logic [3:0]  mon_ff, mon_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic        valid_ff, valid_in;
   logic [5:0]  out_sec_ff, out_sec_in;
   logic [5:0]  out_min_ff, out_min_in;
   logic [4:0]  out_hour_ff, out_hour_in;
   logic [4:0]  out_day_ff, out_day_in;
   logic [3:0]  out_mon_ff, out_mon_in;
   logic [11:0] out_year_ff, out_year_in;
   logic [7:0]  out_short_ff, out_short_in;

   logic [31:0] recip;
   logic [31:0] divisor;
   logic [31:0] quot;
   logic [31:0] rem;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  mon_len;
   logic        year_exit;
   logic        month_exit;

   // Select reciprocal, divisor and quotient bits for the active divide
   always_comb begin
      unique case (ctrl.div)
         DIV_60: begin
            recip   = DIV60_RECIP;
            divisor = DIV60_VALUE;
            quot    = 32'(prod_ff[63:DIV60_SHIFT]);
         end
         DIV_24: begin
            recip   = DIV24_RECIP;
            divisor = DIV24_VALUE;
            quot    = 32'(prod_ff[63:DIV24_SHIFT]);
         end
         default: begin
            recip   = DIV60_RECIP;
            divisor = DIV60_VALUE;
            quot    = 32'(prod_ff[63:DIV60_SHIFT]);
         end
      endcase
      rem = acc_ff - quot * divisor;
   end

   // Gregorian leap rule from the running year residues
   assign leap = ((year_ff[1:0] == 2'b00) && (y100_ff != '0)) || (y400_ff == '0);
   assign year_len   = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
   assign mon_len    = month_days(mon_ff, leap);
   assign year_exit  = acc_ff < 32'(year_len);
   assign month_exit = (mon_ff == MONTH_DEC) || (acc_ff < 32'(mon_len));
   assign status.loop_exit = (ctrl.op == OP_YEAR) ? year_exit : month_exit;

   // Execute one control word
   always_comb begin
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      year_in      = year_ff;
      y100_in      = y100_ff;
      y400_in      = y400_ff;
      mon_in       = mon_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      valid_in     = 1'b0;
      out_sec_in   = out_sec_ff;
      out_min_in   = out_min_ff;
      out_hour_in  = out_hour_ff;
      out_day_in   = out_day_ff;
      out_mon_in   = out_mon_ff;
      out_year_in  = out_year_ff;
      out_short_in = out_short_ff;
      unique case (ctrl.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            acc_in  = req_epoch_seconds;
            year_in = EPOCH_YEAR;
            y100_in = EPOCH_YEAR_MOD100;
            y400_in = EPOCH_YEAR_MOD400;
            mon_in  = '0;
         end
         OP_MUL: begin
            prod_in = 64'(acc_ff) * 64'(recip);
         end
         OP_REM: begin
            acc_in = quot;
            unique case (ctrl.field)
               FIELD_SEC:  sec_in  = rem[5:0];
               FIELD_MIN:  min_in  = rem[5:0];
               FIELD_HOUR: hour_in = rem[4:0];
               default:    sec_in  = rem[5:0];
            endcase
         end
         OP_YEAR: begin
            if (!year_exit) begin
               acc_in  = acc_ff - 32'(year_len);
               year_in = year_ff + 12'd1;
               y100_in = (y100_ff == LAST_MOD100) ? '0 : y100_ff + 7'd1;
               y400_in = (y400_ff == LAST_MOD400) ? '0 : y400_ff + 9'd1;
            end
         end
         OP_MONTH: begin
            if (!month_exit) begin
               acc_in = acc_ff - 32'(mon_len);
               mon_in = mon_ff + 4'd1;
            end
         end
         OP_EMIT: begin
            valid_in     = 1'b1;
            out_sec_in   = sec_ff;
            out_min_in   = min_ff;
            out_hour_in  = hour_ff;
            out_day_in   = acc_ff[4:0] + 5'd1;
            out_mon_in   = mon_ff + 4'd1;
            out_year_in  = year_ff;
            out_short_in = 8'(year_ff - RTC_BASE_YEAR);
         end
         default: begin
         end
      endcase
   end

   // Hold the result strobe under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Advance working and result registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      year_ff      <= year_in;
      y100_ff      <= y100_in;
      y400_ff      <= y400_in;
      mon_ff       <= mon_in;
      sec_ff       <= sec_in;
      min_ff       <= min_in;
      hour_ff      <= hour_in;
      out_sec_ff   <= out_sec_in;
      out_min_ff   <= out_min_in;
      out_hour_ff  <= out_hour_in;
      out_day_ff   <= out_day_in;
      out_mon_ff   <= out_mon_in;
      out_year_ff  <= out_year_in;
      out_short_ff <= out_short_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_second_of_minute = out_sec_ff;
   assign rsp_minute_of_hour   = out_min_ff;
   assign rsp_hour_of_day      = out_hour_ff;
   assign rsp_day_of_month     = out_day_ff;
   assign rsp_month_of_year    = out_mon_ff;
   assign rsp_full_year        = out_year_ff;
   assign rsp_short_year       = out_short_ff;

endmodule

>>> rtl/epoch_to_calendar_date_time_core.sv
// Converts a 32-bit Unix epoch into UTC time of day and Gregorian date.
// Pulse start while busy is low; the epoch is taken at that edge and busy
// rises. A conversion keeps busy high through the divides for seconds,
// minutes and hours, a walk over the whole years past 1970 (0 to 136), one
// year a cycle in a microcoded sequencer, a walk over the whole months past
// January (0 to 11) and a final emit step; the year walk sets most of it.
// When busy falls, rsp_valid is high for exactly one cycle with the result; the
// receiver cannot stall it and must take it then. A new start may be issued
// in that same cycle.
module epoch_to_calendar_date_time_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_of_year,
   output logic [11:0] rsp_full_year,
   output logic [7:0]  rsp_short_year
);
   import ectd_pkg::*;

   step_type      pc_ff, pc_in;
   ctrl_word_type word;
   ctrl_word_type exec_word;
   dp_status_type status;
   logic          accept;

   assign busy   = (pc_ff != STEP_IDLE);
   assign accept = start && !busy;

   // Fetch the control word and pick the next step
   always_comb begin
      word      = microcode(pc_ff);
      exec_word = word;
      pc_in     = pc_ff;
      unique case (word.seq)
         SEQ_WAIT: begin
            if (accept) begin
               pc_in = pc_ff + step_type'(1);
            end else begin
               exec_word.op = OP_NOP;
            end
         end
         SEQ_NEXT: begin
            pc_in = pc_ff + step_type'(1);
         end
         SEQ_LOOP: begin
            if (status.loop_exit) begin
               pc_in = word.branch;
            end
         end
         SEQ_JUMP: begin
            pc_in = word.branch;
         end
         default: begin
            pc_in = STEP_IDLE;
         end
      endcase
   end

   // Hold the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   ectd_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (exec_word),
      .req_epoch_seconds    (req_epoch_seconds),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_of_year    (rsp_month_of_year),
      .rsp_full_year        (rsp_full_year),
      .rsp_short_year       (rsp_short_year)
   );

endmodule

>>> rtl/ectd_checker.sv
// Port-level checks of the epoch converter and their binding
`include "epoch_to_calendar_date_time_core_defines.svh"

module ectd_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [5:0]  rsp_second_of_minute,
   input logic [5:0]  rsp_minute_of_hour,
   input logic [4:0]  rsp_hour_of_day,
   input logic [4:0]  rsp_day_of_month,
   input logic [3:0]  rsp_month_of_year,
   input logic [11:0] rsp_full_year,
   input logic [7:0]  rsp_short_year
);

   logic time_ok;
   logic date_ok;

   // Range of the time-of-day and date fields of a result
   assign time_ok = (rsp_second_of_minute <= 6'd59) && (rsp_minute_of_hour <= 6'd59) &&
                    (rsp_hour_of_day <= 5'd23);
   assign date_ok = (rsp_day_of_month != 5'd0) && (rsp_month_of_year != 4'd0) &&
                    (rsp_month_of_year <= 4'd12) && (rsp_full_year >= 12'd1970) &&
                    (rsp_full_year <= 12'd2106) &&
                    (rsp_short_year == 8'(rsp_full_year - 12'd2000));

   // An accepted transaction makes the block busy
   `ECTD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not raise busy")

   // The result strobe lasts one cycle
   `ECTD_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")

   // A result appears only once the work is done
   `ECTD_ASSERT_SAME(a_result_idle, clock, reset, rsp_valid, !busy, "result while busy")

   // Result fields stay within the calendar
   `ECTD_ASSERT_SAME(a_result_range, clock, reset, rsp_valid, time_ok && date_ok, "result field out of range")

endmodule

bind epoch_to_calendar_date_time_core ectd_checker u_ectd_checker (.*);
